[rtl/mmpvt_pkg.sv]
// ----------------------------------------------------------------------------
// mmpvt_pkg
// Shared constants and controller/datapath interface types for the MIDI
// message parser with voice table.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpvt_pkg;

  // Default voice table depth
  localparam int VOICE_SLOTS_DEF = 8;

  // Event kinds reported with every result beat
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_ADDED     = 4'd1;
  localparam logic [3:0] EV_REMOVED   = 4'd2;
  localparam logic [3:0] EV_UNMATCHED = 4'd3;
  localparam logic [3:0] EV_DROPPED   = 4'd4;
  localparam logic [3:0] EV_DIAL      = 4'd5;
  localparam logic [3:0] EV_SELECT    = 4'd6;
  localparam logic [3:0] EV_WHEEL     = 4'd7;
  localparam logic [3:0] EV_SLIDER    = 4'd8;

  // Status byte matching
  localparam logic [7:0] STAT_HI_MASK  = 8'hf0;
  localparam logic [7:0] STAT_NOTE_ON  = 8'd144;
  localparam logic [7:0] STAT_NOTE_OFF = 8'd128;
  localparam logic [7:0] STAT_PROGRAM  = 8'd192;
  localparam logic [7:0] STAT_SELECT   = 8'd177;
  localparam logic [7:0] STAT_CTRL_A   = 8'd176;
  localparam logic [7:0] STAT_CTRL_B   = 8'd178;
  localparam logic [7:0] STAT_WHEEL_A  = 8'd224;
  localparam logic [7:0] STAT_WHEEL_B  = 8'd231;
  localparam logic [7:0] STAT_SYSEX    = 8'd240;

  // Sysex: the seventh data byte goes to the slider
  localparam logic [2:0] SYSEX_LAST_CNT = 3'd6;

  localparam logic [7:0] WHEEL_RESET = 8'd42;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the accepted byte
    logic parse;       // run the parser on the captured byte
    logic read_idx;    // read table entry at the search index
    logic step_down;   // move search index toward older entries
    logic hit;         // key found: report removal
    logic read_next;   // read the entry above the search index
    logic write_shift; // copy the read entry down one slot, advance index
    logic shrink;      // drop one entry from the table count
    logic emit;        // present the result beat
  } mmpvt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic search;   // captured byte completes a note-off on a non-empty table
    logic match;    // read entry holds the note-off key
    logic idx_zero; // search index at the oldest entry
    logic more;     // entries remain above the search index
  } mmpvt_stat_t;

endpackage

`default_nettype wire

[rtl/mmpvt_dp.sv]
// ----------------------------------------------------------------------------
// mmpvt_dp
// Parser datapath: message state, value registers, voice table memory,
// search index and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpvt_dp
  import mmpvt_pkg::*;
#(
  parameter int VOICE_SLOTS = VOICE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mmpvt_cmd_t  cmd,
  output mmpvt_stat_t      stat,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  output logic [3:0]       out_event_kind,
  output logic [7:0]       out_event_key,
  output logic [7:0]       out_event_velocity,
  output logic [3:0]       out_voice_count,
  output logic [7:0]       out_dial_value,
  output logic [7:0]       out_select_value,
  output logic [7:0]       out_wheel_value,
  output logic [7:0]       out_slider_value
);

  localparam int CW = $clog2(VOICE_SLOTS + 1);
  localparam int AW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam logic [CW-1:0] SLOTS = CW'(VOICE_SLOTS);

  // Parser modes
  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_NOTE_ON  = 3'd1;
  localparam logic [2:0] M_NOTE_OFF = 3'd2;
  localparam logic [2:0] M_PROGRAM  = 3'd3;
  localparam logic [2:0] M_SELECT   = 3'd4;
  localparam logic [2:0] M_CONTROL  = 3'd5;
  localparam logic [2:0] M_WHEEL    = 3'd6;
  localparam logic [2:0] M_SYSEX    = 3'd7;

  logic [7:0]    byte_r;
  logic [2:0]    mode_r, mode_nxt;
  logic [2:0]    count_r, count_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]    dial_r, dial_nxt;
  logic [7:0]    select_r, select_nxt;
  logic [7:0]    wheel_r, wheel_nxt;
  logic [7:0]    slider_r, slider_nxt;
  logic [3:0]    kind_r, kind_nxt;
  logic [7:0]    key_r, key_nxt;
  logic [7:0]    vel_r, vel_nxt;
  logic          valid_r;

  logic [15:0]   voice_mem [VOICE_SLOTS];
  logic [15:0]   rdata_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] idx_inc;
  logic [CW-1:0] idx_ext;
  logic [7:0]    stat_hi;

  assign idx_inc = idx_r + 1'b1;
  assign idx_ext = CW'(idx_r);
  assign raddr   = cmd.read_next ? idx_inc : idx_r;
  assign stat_hi = byte_r & STAT_HI_MASK;

  assign stat.search   = (mode_r == M_NOTE_OFF) && (count_r == 3'd1) && (total_r != '0);
  assign stat.match    = (rdata_r[15:8] == first_r);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.more     = ((idx_ext + 1'b1) < total_r);

  always_comb begin
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    first_nxt  = first_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    dial_nxt   = dial_r;
    select_nxt = select_r;
    wheel_nxt  = wheel_r;
    slider_nxt = slider_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    vel_nxt    = vel_r;
    we         = 1'b0;
    waddr      = total_r[AW-1:0];
    wdata      = {first_r, byte_r};

    if (cmd.parse) begin
      kind_nxt = EV_NONE;
      key_nxt  = 8'd0;
      vel_nxt  = 8'd0;
      if (mode_r == M_IDLE) begin
        priority if (stat_hi == STAT_NOTE_ON) begin
          mode_nxt = M_NOTE_ON;
        end else if (stat_hi == STAT_NOTE_OFF) begin
          mode_nxt = M_NOTE_OFF;
        end else if (stat_hi == STAT_PROGRAM) begin
          mode_nxt = M_PROGRAM;
        end else if (byte_r == STAT_SELECT) begin
          mode_nxt = M_SELECT;
        end else if (byte_r == STAT_CTRL_A || byte_r == STAT_CTRL_B) begin
          mode_nxt = M_CONTROL;
        end else if (byte_r == STAT_WHEEL_A || byte_r == STAT_WHEEL_B) begin
          mode_nxt = M_WHEEL;
        end else if (byte_r == STAT_SYSEX) begin
          mode_nxt = M_SYSEX;
        end else begin
          mode_nxt = M_IDLE;
        end
        count_nxt = 3'd0;
      end else if (mode_r == M_SELECT) begin
        select_nxt = byte_r;
        kind_nxt   = EV_SELECT;
        mode_nxt   = M_IDLE;
      end else if (mode_r == M_SYSEX) begin
        if (count_r == SYSEX_LAST_CNT) begin
          slider_nxt = byte_r;
          kind_nxt   = EV_SLIDER;
          mode_nxt   = M_IDLE;
          count_nxt  = 3'd0;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else if (count_r == 3'd0) begin
        first_nxt = byte_r;
        count_nxt = 3'd1;
      end else begin
        unique case (mode_r)
          M_NOTE_ON: begin
            key_nxt = first_r;
            vel_nxt = byte_r;
            if (total_r < SLOTS) begin
              we        = 1'b1;
              total_nxt = total_r + 1'b1;
              kind_nxt  = EV_ADDED;
            end else begin
              kind_nxt = EV_DROPPED;
            end
          end
          M_NOTE_OFF: begin
            // start the newest-first search; hit overrides the kind
            key_nxt  = first_r;
            kind_nxt = EV_UNMATCHED;
            idx_nxt  = AW'(total_r - 1'b1);
          end
          M_WHEEL: begin
            wheel_nxt = byte_r;
            kind_nxt  = EV_WHEEL;
          end
          default: begin
            dial_nxt = byte_r;
            kind_nxt = EV_DIAL;
          end
        endcase
        mode_nxt  = M_IDLE;
        count_nxt = 3'd0;
      end
    end

    if (cmd.step_down) idx_nxt = idx_r - 1'b1;
    if (cmd.hit)       kind_nxt = EV_REMOVED;
    if (cmd.write_shift) begin
      we      = 1'b1;
      waddr   = idx_r;
      wdata   = rdata_r;
      idx_nxt = idx_inc;
    end
    if (cmd.shrink) total_nxt = total_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      count_r  <= 3'd0;
      first_r  <= 8'd0;
      total_r  <= '0;
      dial_r   <= 8'd0;
      select_r <= 8'd0;
      wheel_r  <= WHEEL_RESET;
      slider_r <= 8'd0;
      valid_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      total_r  <= total_nxt;
      dial_r   <= dial_nxt;
      select_r <= select_nxt;
      wheel_r  <= wheel_nxt;
      slider_r <= slider_nxt;
      valid_r  <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= in_rx_byte;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    vel_r  <= vel_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) voice_mem[waddr] <= wdata;
    if (cmd.read_idx || cmd.read_next) rdata_r <= voice_mem[raddr];
  end

  assign out_valid          = valid_r;
  assign out_event_kind     = kind_r;
  assign out_event_key      = key_r;
  assign out_event_velocity = vel_r;
  assign out_voice_count    = 4'(total_r);
  assign out_dial_value     = dial_r;
  assign out_select_value   = select_r;
  assign out_wheel_value    = wheel_r;
  assign out_slider_value   = slider_r;

endmodule

`default_nettype wire

[rtl/mmpvt_ctrl.sv]
// ----------------------------------------------------------------------------
// mmpvt_ctrl
// Sequencer: accepts a byte, runs the parse step, walks the voice table
// for note-off search and compaction, then issues the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpvt_ctrl
  import mmpvt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  output mmpvt_cmd_t        cmd,
  input  wire mmpvt_stat_t  stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SHCHK = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.parse = 1'b1;
        state_nxt = stat.search ? S_READ : S_EMIT;
      end
      S_READ: begin
        cmd.read_idx = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_SHCHK;
        end else if (stat.idx_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.step_down = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_SHCHK: begin
        if (stat.more) begin
          cmd.read_next = 1'b1;
          state_nxt     = S_SHWR;
        end else begin
          cmd.shrink = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_SHWR: begin
        cmd.write_shift = 1'b1;
        state_nxt       = S_SHCHK;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/midi_message_parser_voice_table.sv]
// ----------------------------------------------------------------------------
// midi_message_parser_voice_table
// MIDI byte parser that keeps a table of held notes, searched newest first,
// and a set of controller value registers, one result beat per byte.
// ----------------------------------------------------------------------------
// Drive one received MIDI byte on in_rx_byte with start high while busy is
// low; that cycle accepts the byte. Exactly one result beat follows, marked
// by out_valid for a single cycle. The receiver cannot stall: capture the
// result in the cycle that out_valid is high, it is not repeated. A byte
// passes from accept through the parse and emit states to its result beat,
// and busy drops in time for the next byte to be accepted in the same cycle
// as that beat. The one exception is the byte that completes a note-off
// while notes are held: the sequencer then walks the voice table memory,
// which has one read port with a registered output, reading (S_READ) and
// comparing (S_CMP) each entry from the newest entry down, and on a hit
// moves every newer entry down one slot (S_SHCHK, S_SHWR), then shrinks the
// count in S_SHCHK before the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_parser_voice_table
  import mmpvt_pkg::*;
#(
  parameter int VOICE_SLOTS = VOICE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  output logic [3:0]       out_event_kind,
  output logic [7:0]       out_event_key,
  output logic [7:0]       out_event_velocity,
  output logic [3:0]       out_voice_count,
  output logic [7:0]       out_dial_value,
  output logic [7:0]       out_select_value,
  output logic [7:0]       out_wheel_value,
  output logic [7:0]       out_slider_value
);

  // Controller and datapath exchange only commands and status.
  mmpvt_cmd_t  cmd;
  mmpvt_stat_t stat;

  // Sequence each byte: accept, parse, optional table walk, result beat.
  mmpvt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Hold parser state, value registers, the voice table and the result.
  mmpvt_dp #(
    .VOICE_SLOTS (VOICE_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_event_kind     (out_event_kind),
    .out_event_key      (out_event_key),
    .out_event_velocity (out_event_velocity),
    .out_voice_count    (out_voice_count),
    .out_dial_value     (out_dial_value),
    .out_select_value   (out_select_value),
    .out_wheel_value    (out_wheel_value),
    .out_slider_value   (out_slider_value)
  );

endmodule

`default_nettype wire
